/* rtl/assert_macros.svh */
// Assertion macros shared by the rational arithmetic unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define RAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rau_pkg.sv */
// Types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int OpW  = 16;
  localparam int ResW = 32;
  localparam int ProdW = 2 * OpW + 2;
  localparam int CntW = $clog2(ProdW);
  localparam int QDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_NEG = 4'd4, OP_MAG = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
    OP_GE  = 4'd8, OP_NE  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    CLS_ARITH, CLS_CMP, CLS_NONE
  } cls_t;

  // Sign-fixed operands plus classification, queued between front and back
  typedef struct packed {
    logic [3:0]              op;
    cls_t                    cls;
    logic signed [OpW:0]     an;
    logic signed [OpW:0]     ad;
    logic signed [OpW:0]     bn;
    logic signed [OpW:0]     bd;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_FORM, ST_GCD, ST_DIV, ST_DONE
  } bst_t;

endpackage

/* rtl/rau_front.sv */
// Front end: sign fix and classification of incoming transfers into a two-entry queue
module rau_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          in_req_type,
  input  logic signed [rau_pkg::OpW-1:0]      in_a_num,
  input  logic signed [rau_pkg::OpW-1:0]      in_a_den,
  input  logic signed [rau_pkg::OpW-1:0]      in_b_num,
  input  logic signed [rau_pkg::OpW-1:0]      in_b_den,
  output logic                                q_valid,
  input  logic                                q_ready,
  output rau_pkg::job_t                       q_job
);
  import rau_pkg::*;

  job_t             mem_r [QDepth];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  job_t             job;
  logic signed [OpW:0] an, ad, bn, bd;
  logic             push, pop;

  always_comb begin
    an = {in_a_num[OpW-1], in_a_num};
    ad = {in_a_den[OpW-1], in_a_den};
    bn = {in_b_num[OpW-1], in_b_num};
    bd = {in_b_den[OpW-1], in_b_den};
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    job.op = in_req_type;
    job.an = an;
    job.ad = ad;
    job.bn = bn;
    job.bd = bd;
    unique case (in_req_type) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_MAG, OP_INC, OP_DEC: job.cls = CLS_ARITH;
      OP_GE, OP_NE: job.cls = CLS_CMP;
      default:      job.cls = CLS_NONE;
    endcase
  end

  assign in_ready = (cnt_r != 2'(QDepth));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= job;
  end

  `include "assert_macros.svh"
  `RAU_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 2'(QDepth), "queue count overflow")
  `RAU_ASSERT_NXT(a_push_only, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
  `RAU_ASSERT_NXT(a_pop_only, pop && !push, cnt_r == $past(cnt_r) - 2'd1, "pop lost")

endmodule

/* rtl/rau_back.sv */
// Back end: products, binary gcd, restoring division and output register
module rau_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  rau_pkg::job_t                     q_job,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rau_pkg::ResW-1:0]   out_res_num,
  output logic signed [rau_pkg::ResW-1:0]   out_res_den,
  output logic                              out_cmp_flag,
  output logic                              out_den_error
);
  import rau_pkg::*;

  bst_t              st_r, st_nxt;
  job_t              job_r;
  logic signed [ProdW-1:0] p1_r, p2_r, p3_r;
  logic signed [ProdW-1:0] n_r, d_r;
  logic [ProdW-1:0]  gx_r, gy_r;
  logic [CntW-1:0]   k_r;
  logic [ProdW-1:0]  g_r;
  logic [ProdW-1:0]  rn_r, rd_r, qn_r, qd_r;
  logic [CntW-1:0]   bit_r;
  logic              nneg_r;
  logic signed [ResW-1:0] on_r, od_r;
  logic              oc_r, oe_r, ov_r;

  logic signed [OpW:0] ma, mb;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] n_c, d_c;
  logic [ProdW-1:0]  tn, td;
  logic [ProdW-1:0]  gx_n, gy_n, dif;

  // One shared multiplier, three products in states ST_MUL1, ST_MUL2 and ST_MUL3
  always_comb begin
    ma = job_r.an;
    mb = job_r.bd;
    unique case (st_r)
      ST_MUL2: begin
        ma = job_r.bn;
        mb = job_r.ad;
      end
      ST_MUL3: begin
        ma = job_r.ad;
        mb = (job_r.op == OP_DIV) ? job_r.bn : job_r.bd;
      end
      default: begin
        ma = job_r.an;
        mb = (job_r.op == OP_MUL) ? job_r.bn : job_r.bd;
      end
    endcase
    prod = ProdW'(ma) * ProdW'(mb);
  end

  always_comb begin
    n_c = '0;
    d_c = ProdW'(job_r.ad);
    unique case (job_r.op) inside
      OP_ADD: begin n_c = p1_r + p2_r; d_c = p3_r; end
      OP_SUB: begin n_c = p1_r - p2_r; d_c = p3_r; end
      OP_MUL, OP_DIV: begin n_c = p1_r; d_c = p3_r; end
      OP_NEG: n_c = -ProdW'(job_r.an);
      OP_MAG: n_c = (job_r.an < 0) ? -ProdW'(job_r.an) : ProdW'(job_r.an);
      OP_INC: n_c = ProdW'(job_r.an) + ProdW'(job_r.ad);
      OP_DEC: n_c = ProdW'(job_r.an) - ProdW'(job_r.ad);
      default: n_c = '0;
    endcase
  end

  always_comb begin
    gx_n = gx_r;
    gy_n = gy_r;
    dif  = '0;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_n = gx_r >> 1;
      gy_n = gy_r >> 1;
    end else if (!gx_r[0]) begin
      gx_n = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_n = gy_r >> 1;
    end else if (gx_r >= gy_r) begin
      dif  = gx_r - gy_r;
      gx_n = dif >> 1;
    end else begin
      dif  = gy_r - gx_r;
      gy_n = dif >> 1;
    end
    tn = {rn_r[ProdW-2:0], qn_r[ProdW-1]};
    td = {rd_r[ProdW-2:0], qd_r[ProdW-1]};
  end

  assign q_ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_MUL1;
      ST_MUL1: st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_MUL3;
      ST_MUL3: st_nxt = ST_FORM;
      ST_FORM: begin
        if (job_r.cls != CLS_ARITH || d_c == 0) st_nxt = ST_DONE;
        else st_nxt = ST_GCD;
      end
      ST_GCD: if (gx_r == 0 || gy_r == 0) st_nxt = ST_DIV;
      ST_DIV: if (bit_r == '0) st_nxt = ST_DONE;
      ST_DONE: if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (st_r == ST_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (q_valid) job_r <= q_job;
      ST_MUL1: p1_r <= prod;
      ST_MUL2: p2_r <= prod;
      ST_MUL3: p3_r <= prod;
      ST_FORM: begin
        if (job_r.cls == CLS_ARITH && d_c < 0) begin
          n_r <= -n_c;
          d_r <= -d_c;
        end else begin
          n_r <= n_c;
          d_r <= d_c;
        end
        gx_r <= (n_c < 0) ? ProdW'(-n_c) : ProdW'(n_c);
        gy_r <= (d_c < 0) ? ProdW'(-d_c) : ProdW'(d_c);
        k_r  <= '0;
      end
      ST_GCD: begin
        gx_r <= gx_n;
        gy_r <= gy_n;
        if (!gx_r[0] && !gy_r[0] && gx_r != 0 && gy_r != 0) k_r <= k_r + CntW'(1);
        if (gx_r == 0 || gy_r == 0) begin
          g_r    <= ((gx_r | gy_r) << k_r);
          nneg_r <= n_r < 0;
          qn_r   <= (n_r < 0) ? ProdW'(-n_r) : ProdW'(n_r);
          qd_r   <= ProdW'(d_r);
          rn_r   <= '0;
          rd_r   <= '0;
          bit_r  <= CntW'(ProdW - 1);
        end
      end
      ST_DIV: begin
        qn_r <= {qn_r[ProdW-2:0], (tn >= g_r)};
        qd_r <= {qd_r[ProdW-2:0], (td >= g_r)};
        rn_r <= (tn >= g_r) ? tn - g_r : tn;
        rd_r <= (td >= g_r) ? td - g_r : td;
        bit_r <= bit_r - CntW'(1);
      end
      default: ;
    endcase
  end

  // A zero numerator keeps its denominator unreduced
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && (!ov_r || out_ready)) begin
      if (job_r.cls == CLS_CMP) begin
        on_r <= '0;
        od_r <= ResW'(1);
        oc_r <= (job_r.op == OP_GE) ? (p1_r >= p2_r) : (p1_r != p2_r);
        oe_r <= 1'b0;
      end else if (job_r.cls == CLS_NONE) begin
        on_r <= '0;
        od_r <= ResW'(1);
        oc_r <= 1'b0;
        oe_r <= 1'b0;
      end else if (d_r == 0) begin
        on_r <= ResW'(n_r);
        od_r <= ResW'(d_r);
        oc_r <= 1'b0;
        oe_r <= 1'b1;
      end else if (n_r == 0) begin
        on_r <= '0;
        od_r <= ResW'(d_r);
        oc_r <= 1'b0;
        oe_r <= 1'b0;
      end else begin
        on_r <= nneg_r ? -ResW'(qn_r) : ResW'(qn_r);
        od_r <= ResW'(qd_r);
        oc_r <= 1'b0;
        oe_r <= 1'b0;
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_res_num   = on_r;
  assign out_res_den   = od_r;
  assign out_cmp_flag  = oc_r;
  assign out_den_error = oe_r;

  `include "assert_macros.svh"
  `RAU_ASSERT_IMP(a_busy_no_take, st_r != ST_IDLE, !q_ready, "queue taken while busy")
  `RAU_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
  `RAU_ASSERT_IMP(a_err_arith, out_valid && out_den_error, !out_cmp_flag, "error on compare")

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit
// Usage:
//   Input channel in_valid/in_ready carries req_type and two fractions
//   a_num/a_den and b_num/b_den; output channel out_valid/out_ready
//   carries res_num/res_den, cmp_flag and den_error, one result per transfer.
//   A front stage sign-fixes and classifies each transfer into a two-entry
//   queue; the back stage runs one item at a time.
//   Each item passes through the shared 17x17 multiplier in ST_MUL1 to
//   ST_MUL3; arithmetic codes then run a binary gcd and a 34-step
//   restoring division of numerator and denominator, while comparisons,
//   unused codes and zero denominators go from ST_FORM to ST_DONE. The
//   back stage takes a new item only once its last result is registered.
//   Reset (rst_n low, synchronous) empties the queue and drops any result.
//   While out_ready is low the result is held; the queue keeps taking up
//   to two further items.
module rational_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        in_req_type,
  input  logic signed [rau_pkg::OpW-1:0]    in_a_num,
  input  logic signed [rau_pkg::OpW-1:0]    in_a_den,
  input  logic signed [rau_pkg::OpW-1:0]    in_b_num,
  input  logic signed [rau_pkg::OpW-1:0]    in_b_den,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rau_pkg::ResW-1:0]   out_res_num,
  output logic signed [rau_pkg::ResW-1:0]   out_res_den,
  output logic                              out_cmp_flag,
  output logic                              out_den_error
);
  import rau_pkg::*;

  logic q_valid, q_ready;
  job_t q_job;

  rau_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_valid, .q_ready, .q_job
  );

  rau_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job, .out_valid, .out_ready,
    .out_res_num, .out_res_den, .out_cmp_flag, .out_den_error
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the rational arithmetic unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  typedef struct {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               cmp;
    logic               err;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int        fails;

    function logic [63:0] mag64(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      if (x == 0 || y == 0) return 64'd1;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function logic [63:0] div_mag(logic [63:0] v, logic [63:0] g);
      logic [63:0] q;
      q = mag64(v) / g;
      return v[63] ? -q : q;
    endfunction

    function void note_input(logic [3:0] op, logic signed [15:0] a_n, logic signed [15:0] a_d,
                             logic signed [15:0] b_n, logic signed [15:0] b_d);
      logic [63:0] an, ad, bn, bd, n, d, g;
      logic cmp, err, arith;
      frac_res_t r;
      an = 64'(a_n); ad = 64'(a_d); bn = 64'(b_n); bd = 64'(b_d);
      if (ad[63]) begin an = -an; ad = -ad; end
      if (bd[63]) begin bn = -bn; bd = -bd; end
      n = 0; d = 1; cmp = 0; err = 0; arith = 1;
      case (op)
        OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
        OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
        OP_MUL: begin n = an * bn; d = ad * bd; end
        OP_DIV: begin n = an * bd; d = ad * bn; end
        OP_NEG: begin n = -an; d = ad; end
        OP_MAG: begin n = mag64(an); d = ad; end
        OP_INC: begin n = an + ad; d = ad; end
        OP_DEC: begin n = an - ad; d = ad; end
        OP_GE: begin
          cmp = $signed(an * bd) >= $signed(bn * ad);
          arith = 0;
        end
        OP_NE: begin
          cmp = (an * bd) != (bn * ad);
          arith = 0;
        end
        default: arith = 0;
      endcase
      if (arith) begin
        if (d == 0) err = 1;
        else begin
          if (d[63]) begin n = -n; d = -d; end
          g = gcd64(mag64(n), mag64(d));
          n = div_mag(n, g);
          d = div_mag(d, g);
        end
      end
      r.num = n[31:0]; r.den = d[31:0]; r.cmp = cmp; r.err = err;
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] num, logic signed [31:0] den,
                               logic cmp, logic err);
      frac_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        fails++;
        return;
      end
      e = pending.pop_front();
      if (num !== e.num) begin
        $error("res_num expected %0d actual %0d", e.num, num); fails++;
      end
      if (den !== e.den) begin
        $error("res_den expected %0d actual %0d", e.den, den); fails++;
      end
      if (cmp !== e.cmp) begin
        $error("cmp_flag expected %0b actual %0b", e.cmp, cmp); fails++;
      end
      if (err !== e.err) begin
        $error("den_error expected %0b actual %0b", e.err, err); fails++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic [3:0] in_req_type;
  logic signed [15:0] in_a_num, in_a_den, in_b_num, in_b_den;
  logic signed [31:0] out_res_num, out_res_den;
  logic out_cmp_flag, out_den_error;
  frac_scoreboard sb;
  int cycles;
  bit calm;
  localparam int CycleLimit = 1400 * 400 + 50000;

  rational_arithmetic_unit i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** rational_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_res_num, out_res_den, out_cmp_flag, out_den_error);
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  function logic signed [15:0] rand_field();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh8001;
      3: return 16'sd0;
      4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [3:0] op, logic signed [15:0] an, logic signed [15:0] ad,
                      logic signed [15:0] bn, logic signed [15:0] bd);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 15) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= op; in_a_num <= an; in_a_den <= ad; in_b_num <= bn; in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, an, ad, bn, bd);
  endtask

  initial begin
    sb = new();
    cycles = 0; calm = 0;
    rst_n = 0; in_valid = 0; out_ready = 0;
    in_req_type = 0; in_a_num = 0; in_a_den = 1; in_b_num = 0; in_b_den = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int op = 0; op < 16; op++) send(op[3:0], 16'sd6, -16'sd4, -16'sd3, 16'sd9);
    send(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8001);
    send(OP_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd7);
    send(OP_ADD, 16'sd0, 16'sd8, 16'sd0, 16'sd4);
    send(OP_GE, 16'sd1, 16'sd0, 16'sd2, 16'sd0);
    send(OP_NE, 16'sd1, 16'sd0, 16'sd2, 16'sd3);
    send(OP_NEG, 16'sd3, 16'sd0, 16'sd0, 16'sd0);
    send(OP_INC, 16'sh8000, 16'sh8000, 16'sd0, 16'sd1);
    for (int i = 0; i < 1400; i++) begin
      calm = (i >= 400 && i < 600);
      if (i == 700) begin
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send((i % 20 == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9)),
           rand_field(), rand_field(), rand_field(), rand_field());
    end
    calm = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("** rational_arithmetic_unit: PASSED **");
    else
      $display("** rational_arithmetic_unit: FAILED **");
    $finish;
  end
endmodule
